/* rtl/midpoint_circle_rasterizer_defines.svh */
// Assertion macros used by the checker of the circle rasterizer.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define MCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, masked during reset.
`define MCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define MCR_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

/* rtl/mcr_pkg.sv */
// Package: widths, codes and the point job record of the circle rasterizer.
package mcr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 10;
  localparam int QUAD_BITS   = 3;
  localparam int POINT_BITS  = COORD_BITS + 1;
  localparam int DEC_BITS    = RADIUS_BITS + 3;
  // Room for centre +/- offset without overflow before the final wrap.
  localparam int WIDE_BITS   = (RADIUS_BITS + 2 > POINT_BITS) ? RADIUS_BITS + 2 : POINT_BITS;
  localparam int IDX_BITS    = 3;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [QUAD_BITS-1:0] QUAD_ALL  = 3'd0;
  localparam logic [QUAD_BITS-1:0] QUAD_LAST = 3'd4;

  localparam logic [IDX_BITS-1:0] IDX_FIRST = 3'd0;
  localparam logic [IDX_BITS-1:0] IDX_FINAL = 3'd7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic [RADIUS_BITS-1:0]       x;
    logic [RADIUS_BITS-1:0]       y;
    logic [IDX_BITS-1:0]          first;
    logic [IDX_BITS-1:0]          last;
    logic                         done;
  } job_t;

endpackage

/* rtl/mcr_in_if.sv */
// Request channel of the circle rasterizer: start or step commands.
interface mcr_in_if import mcr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [RADIUS_BITS-1:0]       radius;
  logic [QUAD_BITS-1:0]         quadrant;

  modport source (output valid, mode, center_x, center_y, radius, quadrant, input ready);
  modport sink   (input valid, mode, center_x, center_y, radius, quadrant, output ready);
endinterface

/* rtl/mcr_out_if.sv */
// Point channel of the circle rasterizer.
interface mcr_out_if import mcr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [POINT_BITS-1:0] point_x;
  logic signed [POINT_BITS-1:0] point_y;
  logic                         last_of_step;
  logic                         circle_done;

  modport source (output valid, point_x, point_y, last_of_step, circle_done, input ready);
  modport sink   (input valid, point_x, point_y, last_of_step, circle_done, output ready);
endinterface

/* rtl/mcr_step.sv */
// Midpoint step unit: holds the circle state and builds a point job per request.
module mcr_step import mcr_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic [RADIUS_BITS-1:0]       radius,
  input  logic [QUAD_BITS-1:0]         quadrant,
  output job_t                         job,
  output logic                         job_load
);

  logic signed [COORD_BITS-1:0] centre_x_reg, centre_x_reg_next;
  logic signed [COORD_BITS-1:0] centre_y_reg, centre_y_reg_next;
  logic [QUAD_BITS-1:0]         quadrant_reg, quadrant_reg_next;
  logic [RADIUS_BITS-1:0]       step_x, step_x_next;
  logic [RADIUS_BITS-1:0]       step_y, step_y_next;
  logic signed [DEC_BITS-1:0]   decision, decision_next;
  logic                         active;
  logic                         update;
  logic                         done_next;
  logic signed [DEC_BITS-1:0]   x_ext, y_ext;
  logic [QUAD_BITS-1:0]         quad_m1;

  // A step request while idle leaves everything untouched.
  assign update = fire && ((mode == MODE_START) || active);

  always_comb begin
    centre_x_reg_next = centre_x_reg;
    centre_y_reg_next = centre_y_reg;
    quadrant_reg_next = quadrant_reg;
    step_x_next       = step_x;
    step_y_next       = step_y;
    decision_next     = decision;
    x_ext             = '0;
    y_ext             = '0;
    if (mode == MODE_START) begin
      centre_x_reg_next = center_x;
      centre_y_reg_next = center_y;
      quadrant_reg_next = quadrant;
      step_x_next       = '0;
      step_y_next       = radius;
      decision_next     = DEC_BITS'(1) - DEC_BITS'(radius);
    end else begin
      step_x_next = step_x + 1'b1;
      x_ext       = DEC_BITS'(step_x_next);
      if (decision < 0) begin
        decision_next = decision + (x_ext <<< 1) + DEC_BITS'(1);
      end else begin
        step_y_next   = step_y - 1'b1;
        y_ext         = DEC_BITS'(step_y_next);
        decision_next = decision + ((x_ext - y_ext) <<< 1) + DEC_BITS'(1);
      end
    end
  end

  assign done_next = !(step_x_next < step_y_next);
  assign quad_m1   = quadrant_reg_next - 1'b1;

  always_comb begin
    job.cx   = centre_x_reg_next;
    job.cy   = centre_y_reg_next;
    job.x    = step_x_next;
    job.y    = step_y_next;
    job.done = done_next;
    if (quadrant_reg_next == QUAD_ALL) begin
      job.first = IDX_FIRST;
      job.last  = IDX_FINAL;
    end else begin
      job.first = {quad_m1[1:0], 1'b0};
      job.last  = {quad_m1[1:0], 1'b1};
    end
  end

  // Selections above the last quadrant update state but plot nothing.
  assign job_load = update && (quadrant_reg_next <= QUAD_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x_reg <= '0;
      centre_y_reg <= '0;
      quadrant_reg <= '0;
      step_x       <= '0;
      step_y       <= '0;
      decision     <= '0;
      active       <= 1'b0;
    end else if (update) begin
      centre_x_reg <= centre_x_reg_next;
      centre_y_reg <= centre_y_reg_next;
      quadrant_reg <= quadrant_reg_next;
      step_x       <= step_x_next;
      step_y       <= step_y_next;
      decision     <= decision_next;
      active       <= !done_next;
    end
  end

endmodule

/* rtl/mcr_emit.sv */
// Point emitter: walks one job's mirrored points into the output register.
module mcr_emit import mcr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      job_in,
  input  logic      job_load,
  output logic      job_free,
  mcr_out_if.source point
);

  job_t                job;
  logic                job_valid;
  logic [IDX_BITS-1:0] idx;
  logic                advance;
  logic                at_last;
  logic [1:0]          pair;
  logic                swap;
  logic [RADIUS_BITS-1:0] a, b;
  logic [WIDE_BITS-1:0]   a_w, b_w, cx_w, cy_w, px_w, py_w;

  assign advance  = job_valid && (!point.valid || point.ready);
  assign at_last  = (idx == job.last);
  assign job_free = !job_valid || (advance && at_last);

  // Point order: pair selects the quadrant, swap picks the (y, x) mirror.
  assign pair = idx[2:1];
  assign swap = idx[0];
  assign a    = swap ? job.y : job.x;
  assign b    = swap ? job.x : job.y;
  assign a_w  = {{(WIDE_BITS-RADIUS_BITS){1'b0}}, a};
  assign b_w  = {{(WIDE_BITS-RADIUS_BITS){1'b0}}, b};
  assign cx_w = {{(WIDE_BITS-COORD_BITS){job.cx[COORD_BITS-1]}}, job.cx};
  assign cy_w = {{(WIDE_BITS-COORD_BITS){job.cy[COORD_BITS-1]}}, job.cy};
  assign px_w = pair[1] ? (cx_w - a_w) : (cx_w + a_w);
  assign py_w = (pair[1] == pair[0]) ? (cy_w - b_w) : (cy_w + b_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid   <= 1'b0;
      point.valid <= 1'b0;
    end else begin
      if (advance) begin
        point.valid <= 1'b1;
      end else if (point.ready) begin
        point.valid <= 1'b0;
      end
      // A new job only arrives while no job is held or the current one is moving its last point.
      if (job_load) begin
        job_valid <= 1'b1;
        idx       <= job_in.first;
      end else if (advance) begin
        idx <= idx + 1'b1;
        if (at_last) begin
          job_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end
    if (advance) begin
      point.point_x      <= px_w[POINT_BITS-1:0];
      point.point_y      <= py_w[POINT_BITS-1:0];
      point.last_of_step <= at_last;
      point.circle_done  <= job.done;
    end
  end

endmodule

/* rtl/midpoint_circle_rasterizer.sv */
// Midpoint circle rasterizer top level.
// Channels: item (sink) takes start requests (mode 0: centre, radius, quadrant)
// and step requests (mode 1: one midpoint step); point (source) gives one
// plotted point per transfer, last_of_step on the final point of a request and
// circle_done on every point of the request that finishes the circle.
// Quadrant 0 yields eight points per request, quadrants 1..4 yield two, codes
// 5..7 and step requests while idle yield none.
// An accepted request is registered as a job in the emitter, whose points then
// pass one by one through the single point output register, which paces the
// requests; a request that yields none never occupies the emitter.
// The next request is taken in the cycle the current one's last point moves to
// the output register, so requests follow with no gap.
// Reset: synchronous, clears the circle state to idle and drops point.valid.
// Stall: while point.ready is low a valid output point holds, and item.ready
// falls once a request's points are still waiting behind it.
module midpoint_circle_rasterizer import mcr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  mcr_in_if.sink    item,
  mcr_out_if.source point
);

  job_t job;
  logic job_load;
  logic job_free;
  logic fire;

  assign item.ready = job_free;
  assign fire       = item.valid && item.ready;

  mcr_step u_step (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .mode     (item.mode),
    .center_x (item.center_x),
    .center_y (item.center_y),
    .radius   (item.radius),
    .quadrant (item.quadrant),
    .job      (job),
    .job_load (job_load)
  );

  mcr_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .job_in   (job),
    .job_load (job_load),
    .job_free (job_free),
    .point    (point)
  );

endmodule

/* rtl/mcr_checker.sv */
// Port-level checks of the circle rasterizer, bound to the top level.
`include "midpoint_circle_rasterizer_defines.svh"

module mcr_checker (
  input logic clk,
  input logic rst,
  input logic item_ready,
  input logic point_valid,
  input logic point_ready,
  input logic point_last,
  input logic point_done
);

  `MCR_ASSERT_RST(a_reset_idle, !point_valid, "point valid right after reset")

  `MCR_ASSERT_NXT(a_stall_hold, point_valid && !point_ready, point_valid,
                  "point dropped while stalled")

  `MCR_ASSERT_NXT(a_points_burst, point_valid && point_ready && !point_last, point_valid,
                  "gap inside the points of one request")

  `MCR_ASSERT_NXT(a_done_steady, point_valid && point_ready && !point_last,
                  point_done == $past(point_done), "circle_done changed within a request")

  `MCR_ASSERT_IMP(a_busy_block, point_valid && !point_ready && !point_last, !item_ready,
                  "request taken while points still queued")

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (
  .clk         (clk),
  .rst         (rst),
  .item_ready  (item.ready),
  .point_valid (point.valid),
  .point_ready (point.ready),
  .point_last  (point.last_of_step),
  .point_done  (point.circle_done)
);
